// ----- hdl/assert_macros.svh -----
// Assertion macros used by the checker file.
// Plain property wrappers, no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ----- hdl/gbsp_pkg.sv -----
// Package for the grid shortest-path block: sizes, types, state codes.
// No dependencies.
`timescale 1ns / 1ps
package gbsp_pkg;
  localparam int MaxRowsDef = 64;
  localparam int MaxColsDef = 64;
  localparam int CoordW = 7;
  localparam int DistW = 13;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_CLEAR,
    ST_SEED,
    ST_POP,
    ST_POPWAIT,
    ST_NBR,
    ST_NBRWAIT,
    ST_TGT,
    ST_TGTWAIT,
    ST_DONE
  } state_t;

  // Neighbor direction codes, in search order.
  typedef enum logic [1:0] {
    DIR_RIGHT,
    DIR_LEFT,
    DIR_DOWN,
    DIR_UP
  } dir_t;
endpackage

// ----- hdl/gbsp_ram.sv -----
// Single-port synchronous RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
module gbsp_ram #(
  parameter int Depth = 16,
  parameter int Width = 1
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // Read first (a write returns the old word), read registered.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ----- hdl/grid_bfs_shortest_path.sv -----
// Grid shortest-path top level: handshakes, search sequencer, memories.
// Depends on gbsp_pkg and gbsp_ram.
//
// Usage:
//  - cfg channel: index 0 writes grid_rows, index 1 grid_cols; write only
//    while idle. Ready is always high.
//  - in channel: func 0 writes one obstacle cell (no result);
//    func 1 runs a query and yields one out transaction (distance, reachable).
//  - A query first clears the visited map, one cell a cycle over all
//    (MAX_ROWS+2)*(MAX_COLS+2) cells (4356 at default size), then runs a
//    breadth-first search through one shared address unit: it pops each
//    queued cell, then tries its four neighbors in search order, skipping
//    a direction off the edge without waiting on the memories. The pace is
//    set by the single port of each cell memory.
//  - in_ready is low from acceptance until the result is taken; a stalled
//    receiver holds out_valid and the payload until out_ready.
//  - Reset (rst_n low, synchronous) returns to idle, restores 64 by 64 and
//    clears the obstacle map by a pass of one cell a cycle; in_ready stays
//    low for that pass.
`timescale 1ns / 1ps
module grid_bfs_shortest_path #(
  parameter int MAX_ROWS = gbsp_pkg::MaxRowsDef,
  parameter int MAX_COLS = gbsp_pkg::MaxColsDef
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic                         cfg_index,
  input  logic [gbsp_pkg::CoordW-1:0]  cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_func,
  input  logic [gbsp_pkg::CoordW-1:0]  in_row,
  input  logic [gbsp_pkg::CoordW-1:0]  in_col,
  input  logic                         in_blocked,
  input  logic [gbsp_pkg::CoordW-1:0]  in_target_row,
  input  logic [gbsp_pkg::CoordW-1:0]  in_target_col,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [gbsp_pkg::DistW-1:0]   out_distance,
  output logic                         out_reachable
);
  localparam int GridH = MAX_ROWS + 2;
  localparam int GridW = MAX_COLS + 2;
  localparam int Cells = GridH * GridW;
  localparam int AW = $clog2(Cells);
  localparam int RW = $clog2(GridH);
  localparam int CW = $clog2(GridW);
  localparam int QW = $clog2(Cells + 1);
  localparam int DW = gbsp_pkg::DistW;

  // Configuration registers.
  logic [6:0] rows_r, cols_r;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= 7'd64;
      cols_r <= 7'd64;
    end else if (cfg_valid) begin
      if (cfg_index) cols_r <= cfg_data;
      else rows_r <= cfg_data;
    end
  end

  // Clamped limits (last usable index).
  logic [7:0] lim_r, lim_c;
  always_comb begin
    if (rows_r == 7'd0) lim_r = 8'd2;
    else if (32'(rows_r) > MAX_ROWS) lim_r = 8'(MAX_ROWS + 1);
    else lim_r = {1'b0, rows_r} + 8'd1;
    if (cols_r == 7'd0) lim_c = 8'd2;
    else if (32'(cols_r) > MAX_COLS) lim_c = 8'(MAX_COLS + 1);
    else lim_c = {1'b0, cols_r} + 8'd1;
  end

  gbsp_pkg::state_t st_r, st_nxt;
  logic        init_r, init_nxt;
  logic [AW:0] sweep_r, sweep_nxt;
  logic [6:0]  sr_r, sc_r, tr_r, tc_r;
  logic        func_r, blk_r;
  logic [RW-1:0] cur_r_r, cur_r_nxt;
  logic [CW-1:0] cur_c_r, cur_c_nxt;
  logic [DW-1:0] cur_d_r, cur_d_nxt;
  logic [1:0]  dir_r, dir_nxt;
  logic [QW-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [DW-1:0] dist_r, dist_nxt;
  logic        reach_r, reach_nxt;
  logic        oval_r, oval_nxt;

  // Memory ports.
  logic          obs_we, obs_wd, obs_rd;
  logic [AW-1:0] obs_a;
  logic          vis_we, vis_wd, vis_rd;
  logic [AW-1:0] vis_a;
  logic          dst_we;
  logic [AW-1:0] dst_a;
  logic [DW-1:0] dst_wd, dst_rd;
  logic          q_we;
  logic [AW-1:0] q_a, q_wd, q_rd;

  gbsp_ram #(.Depth(Cells), .Width(1)) u_obs (
    .clk(clk), .we(obs_we), .addr(obs_a), .wdata(obs_wd), .rdata(obs_rd));
  gbsp_ram #(.Depth(Cells), .Width(1)) u_vis (
    .clk(clk), .we(vis_we), .addr(vis_a), .wdata(vis_wd), .rdata(vis_rd));
  gbsp_ram #(.Depth(Cells), .Width(DW)) u_dst (
    .clk(clk), .we(dst_we), .addr(dst_a), .wdata(dst_wd), .rdata(dst_rd));
  gbsp_ram #(.Depth(Cells), .Width(AW)) u_q (
    .clk(clk), .we(q_we), .addr(q_a), .wdata(q_wd), .rdata(q_rd));

  // Shared address unit: row*GridW + col for the selected cell.
  logic [RW-1:0] au_r;
  logic [CW-1:0] au_c;
  logic [AW-1:0] au_addr;
  assign au_addr = AW'(au_r * GridW) + AW'(au_c);

  // Neighbor coordinates and legality for the current direction.
  logic [RW-1:0] nb_r;
  logic [CW-1:0] nb_c;
  logic          nb_ok;
  always_comb begin
    nb_r = cur_r_r;
    nb_c = cur_c_r;
    nb_ok = 1'b0;
    unique case (gbsp_pkg::dir_t'(dir_r))
      gbsp_pkg::DIR_RIGHT: begin
        nb_ok = 8'(cur_c_r) < lim_c;
        nb_c = cur_c_r + CW'(1);
      end
      gbsp_pkg::DIR_LEFT: begin
        nb_ok = cur_c_r != '0;
        nb_c = cur_c_r - CW'(1);
      end
      gbsp_pkg::DIR_DOWN: begin
        nb_ok = 8'(cur_r_r) < lim_r;
        nb_r = cur_r_r + RW'(1);
      end
      gbsp_pkg::DIR_UP: begin
        nb_ok = cur_r_r != '0;
        nb_r = cur_r_r - RW'(1);
      end
    endcase
  end

  logic is_tgt;
  assign is_tgt = (7'(nb_r) == tr_r) && (7'(nb_c) == tc_r);

  // Row and column of each queued cell, kept beside its address so a pop
  // needs no division by the grid width.
  logic [RW+CW-1:0] qc_wd, qc_rd;
  logic             qc_we;
  gbsp_ram #(.Depth(Cells), .Width(RW + CW)) u_qc (
    .clk(clk), .we(qc_we), .addr(q_a), .wdata(qc_wd), .rdata(qc_rd));

  logic in_hs;
  assign in_hs = in_valid && in_ready;
  assign in_ready = (st_r == gbsp_pkg::ST_IDLE) && !init_r && !oval_r;

  always_ff @(posedge clk) begin
    if (in_hs) begin
      func_r <= in_func;
      blk_r  <= in_blocked;
      sr_r   <= in_row;
      sc_r   <= in_col;
      tr_r   <= in_target_row;
      tc_r   <= in_target_col;
    end
  end

  // State and control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= gbsp_pkg::ST_IDLE;
      init_r  <= 1'b1;
      sweep_r <= '0;
      oval_r  <= 1'b0;
      head_r  <= '0;
      tail_r  <= '0;
      dir_r   <= '0;
    end else begin
      st_r    <= st_nxt;
      init_r  <= init_nxt;
      sweep_r <= sweep_nxt;
      oval_r  <= oval_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      dir_r   <= dir_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r_r <= cur_r_nxt;
    cur_c_r <= cur_c_nxt;
    cur_d_r <= cur_d_nxt;
    dist_r  <= dist_nxt;
    reach_r <= reach_nxt;
  end

  // Sequencer.
  always_comb begin
    st_nxt = st_r;
    init_nxt = init_r;
    sweep_nxt = sweep_r;
    oval_nxt = oval_r;
    head_nxt = head_r;
    tail_nxt = tail_r;
    dir_nxt = dir_r;
    cur_r_nxt = cur_r_r;
    cur_c_nxt = cur_c_r;
    cur_d_nxt = cur_d_r;
    dist_nxt = dist_r;
    reach_nxt = reach_r;
    au_r = nb_r;
    au_c = nb_c;
    obs_we = 1'b0;
    obs_wd = 1'b0;
    obs_a = au_addr;
    vis_we = 1'b0;
    vis_wd = 1'b0;
    vis_a = au_addr;
    dst_we = 1'b0;
    dst_wd = cur_d_r + DW'(1);
    dst_a = au_addr;
    q_we = 1'b0;
    q_a = AW'(tail_r);
    q_wd = au_addr;
    qc_we = 1'b0;
    qc_wd = {nb_r, nb_c};
    if (oval_r && out_ready) oval_nxt = 1'b0;
    unique case (st_r)
      gbsp_pkg::ST_IDLE: begin
        if (init_r) begin
          // Obstacle map clearing pass after reset.
          obs_we = 1'b1;
          obs_a = AW'(sweep_r);
          if (sweep_r == (AW+1)'(Cells - 1)) begin
            init_nxt = 1'b0;
            sweep_nxt = '0;
          end else begin
            sweep_nxt = sweep_r + 1'b1;
          end
        end else if (in_hs) begin
          st_nxt = gbsp_pkg::ST_CHECK;
        end
      end
      gbsp_pkg::ST_CHECK: begin
        au_r = RW'(sr_r);
        au_c = CW'(sc_r);
        if (!func_r) begin
          obs_a = au_addr;
          obs_wd = blk_r;
          obs_we = (32'(sr_r) < GridH) && (32'(sc_r) < GridW);
          st_nxt = gbsp_pkg::ST_IDLE;
        end else if ({1'b0, sr_r} > lim_r || {1'b0, sc_r} > lim_c ||
                     {1'b0, tr_r} > lim_r || {1'b0, tc_r} > lim_c) begin
          dist_nxt = '0;
          reach_nxt = 1'b0;
          st_nxt = gbsp_pkg::ST_DONE;
        end else begin
          sweep_nxt = '0;
          st_nxt = gbsp_pkg::ST_CLEAR;
        end
      end
      gbsp_pkg::ST_CLEAR: begin
        vis_we = 1'b1;
        vis_a = AW'(sweep_r);
        if (sweep_r == (AW+1)'(Cells - 1)) begin
          sweep_nxt = '0;
          st_nxt = gbsp_pkg::ST_SEED;
        end else begin
          sweep_nxt = sweep_r + 1'b1;
        end
      end
      gbsp_pkg::ST_SEED: begin
        au_r = RW'(sr_r);
        au_c = CW'(sc_r);
        vis_a = au_addr;
        vis_we = 1'b1;
        vis_wd = 1'b1;
        dst_a = au_addr;
        dst_we = 1'b1;
        dst_wd = '0;
        q_a = '0;
        q_we = 1'b1;
        q_wd = au_addr;
        qc_we = 1'b1;
        qc_wd = {RW'(sr_r), CW'(sc_r)};
        head_nxt = '0;
        tail_nxt = QW'(1);
        st_nxt = gbsp_pkg::ST_POP;
      end
      gbsp_pkg::ST_POP: begin
        if (head_r == tail_r) begin
          au_r = RW'(tr_r);
          au_c = CW'(tc_r);
          vis_a = au_addr;
          dst_a = au_addr;
          st_nxt = gbsp_pkg::ST_TGT;
        end else begin
          q_a = AW'(head_r);
          head_nxt = head_r + 1'b1;
          st_nxt = gbsp_pkg::ST_POPWAIT;
        end
      end
      gbsp_pkg::ST_POPWAIT: begin
        // Queue read is out; fetch the cell's distance.
        q_a = AW'(head_r - 1'b1);
        dst_a = q_rd;
        if (dst_a == q_rd) begin
          cur_r_nxt = qc_rd[RW+CW-1:CW];
          cur_c_nxt = qc_rd[CW-1:0];
        end
        dir_nxt = '0;
        st_nxt = gbsp_pkg::ST_NBR;
      end
      gbsp_pkg::ST_NBR: begin
        // First visit here latches the distance of the popped cell.
        if (dir_r == 2'd0) cur_d_nxt = dst_rd;
        if (nb_ok) begin
          st_nxt = gbsp_pkg::ST_NBRWAIT;
        end else if (dir_r == 2'd3) begin
          st_nxt = gbsp_pkg::ST_POP;
        end else begin
          dir_nxt = dir_r + 2'd1;
        end
      end
      gbsp_pkg::ST_NBRWAIT: begin
        if (!vis_rd && (!obs_rd || is_tgt) && 32'(tail_r) < Cells) begin
          vis_we = 1'b1;
          vis_wd = 1'b1;
          dst_we = 1'b1;
          q_we = 1'b1;
          qc_we = 1'b1;
          tail_nxt = tail_r + 1'b1;
        end
        if (dir_r == 2'd3) begin
          st_nxt = gbsp_pkg::ST_POP;
        end else begin
          dir_nxt = dir_r + 2'd1;
          st_nxt = gbsp_pkg::ST_NBR;
        end
      end
      gbsp_pkg::ST_TGT: begin
        au_r = RW'(tr_r);
        au_c = CW'(tc_r);
        vis_a = au_addr;
        dst_a = au_addr;
        st_nxt = gbsp_pkg::ST_TGTWAIT;
      end
      gbsp_pkg::ST_TGTWAIT: begin
        reach_nxt = vis_rd;
        dist_nxt = vis_rd ? dst_rd : '0;
        st_nxt = gbsp_pkg::ST_DONE;
      end
      gbsp_pkg::ST_DONE: begin
        oval_nxt = 1'b1;
        st_nxt = gbsp_pkg::ST_IDLE;
      end
      default: st_nxt = gbsp_pkg::ST_IDLE;
    endcase
  end

  assign out_valid = oval_r;
  assign out_distance = dist_r;
  assign out_reachable = reach_r;
endmodule

// ----- hdl/gbsp_checker.sv -----
// Port-level checker for the grid shortest-path block, bound to the top.
// Depends on assert_macros.svh and gbsp_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module gbsp_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        in_func,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [gbsp_pkg::DistW-1:0]  out_distance,
  input logic                        out_reachable
);
  `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready,
    "ready high right after a transaction")
  `ASSERT_IMPL(a_no_accept_with_result, clk, rst_n, out_valid, !in_ready,
    "input taken while a result waits")
  `ASSERT_IMPL(a_unreach_zero, clk, rst_n, out_valid && !out_reachable,
    out_distance == '0, "unreachable result with nonzero distance")
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
    out_valid && $stable(out_distance), "stalled result changed")
  `ASSERT_NEXT(a_write_no_result, clk, rst_n, in_valid && in_ready && !in_func,
    !out_valid, "cell write produced a result")
endmodule

bind grid_bfs_shortest_path gbsp_checker u_gbsp_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .in_func(in_func), .out_valid(out_valid), .out_ready(out_ready),
  .out_distance(out_distance), .out_reachable(out_reachable));
